// File: hw/rtl/rsd_pkg.sv
// shared types and constants of the run-length sprite decoder
package rsd_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int PIX_ADDR_W      = 20;
  localparam int CFG_DATA_W      = 16;
  localparam int OUTQ_DEPTH      = 4;
  localparam int OUTQ_PTR_W      = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W      = $clog2(OUTQ_DEPTH + 1);

  // configuration register indexes
  localparam logic REG_RECORD_LENGTH = 1'b0;
  localparam logic REG_ROTATE_MODE   = 1'b1;

  localparam logic [15:0] MIN_RECORD_LENGTH = 16'd8;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_COUNT  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_RUNLEN = 3'd3,
    PH_PIXEL  = 3'd4,
    PH_IDLE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic                  kind;
    logic [PIX_ADDR_W-1:0] pixel_address;
    logic [7:0]            color_index;
    logic [15:0]           pic_width;
    logic [15:0]           pic_height;
    logic [15:0]           offset_x;
    logic [15:0]           offset_y;
    logic                  oversize;
    logic                  last;
  } res_t;

  // results of one decoded byte: pixel first, done second
  typedef struct packed {
    logic pix_vld;
    res_t pix;
    logic done_vld;
    res_t done;
  } step_res_t;

endpackage

// File: hw/rtl/rsd_core.sv
// decode state and per-byte step logic of the run-length sprite decoder
module rsd_core #(
  parameter int MAX_DIM = rsd_pkg::MAX_DIM_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       record_length_i,
  input  logic              rotate_mode_i,
  output rsd_pkg::step_res_t res_o
);

  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int COL_W    = $clog2(MAX_DIM + 256);
  localparam int ADDR_RAW = $clog2(MAX_DIM * (MAX_DIM + 257) + 1);
  localparam int ADDR_W   = (ADDR_RAW > rsd_pkg::PIX_ADDR_W) ? ADDR_RAW : rsd_pkg::PIX_ADDR_W;
  localparam logic signed [16:0] MAX_S = 17'(MAX_DIM);

  rsd_pkg::phase_e    phase_q, phase_d;
  logic [15:0]        bc_q, bc_d;
  logic [3:0][15:0]   hdr_q, hdr_d, hdr_cur;
  logic [DIM_W-1:0]   row_q, row_d, row_n, row_c;
  logic [COL_W-1:0]   col_q, col_d, col_inc, skip_x, ar_col;
  logic [7:0]         total_q, total_d;
  logic [8:0]         seen_q, seen_d, seen_inc, ar_seen;
  logic [7:0]         run_q, run_d;
  logic [ADDR_W-1:0]  line_rm_q, line_rm_d, line_rm_n, line_rm_c;
  logic [DIM_W-1:0]   line_rot_q, line_rot_d, line_rot_n, line_rot_c;
  logic [ADDR_W-1:0]  addr_rm_q, addr_rm_d, addr_rot_q, addr_rot_d, addr_sel;
  logic [ADDR_W-1:0]  area_q, area_d, skip_rot;
  logic [DIM_W-1:0]   w_u, h_u;
  logic [15:0]        rl_eff;
  logic [16:0]        bc1, bc2;
  logic               done, stop1, stop2, hdr_ok, oversize;
  logic               ar_en, cnt_en, cnt_next_row;

  assign w_u      = hdr_q[0][DIM_W-1:0];
  assign h_u      = hdr_q[1][DIM_W-1:0];
  assign rl_eff   = (record_length_i < rsd_pkg::MIN_RECORD_LENGTH) ?
                    rsd_pkg::MIN_RECORD_LENGTH : record_length_i;
  assign bc1      = {1'b0, bc_q} + 17'd1;
  assign bc2      = {1'b0, bc_q} + 17'd2;
  assign done     = bc1 >= {1'b0, rl_eff};
  assign stop1    = done;
  assign stop2    = bc2 >= {1'b0, rl_eff};

  assign row_n      = row_q + DIM_W'(1);
  assign line_rm_n  = line_rm_q + ADDR_W'(w_u);
  assign line_rot_n = line_rot_q - DIM_W'(1);
  assign skip_x     = col_q + COL_W'(byte_i);
  assign skip_rot   = ADDR_W'(byte_i) * ADDR_W'(h_u);
  assign col_inc    = col_q + COL_W'(1);
  assign seen_inc   = (seen_q == 9'd511) ? seen_q : seen_q + 9'd1;

  // header words including the byte at hand
  always_comb begin
    hdr_cur = hdr_q;
    if (phase_q == rsd_pkg::PH_HEADER) begin
      hdr_cur[bc_q[2:1]][{bc_q[0], 3'b000} +: 8] = byte_i;
    end
  end

  assign oversize = ($signed({hdr_cur[0][15], hdr_cur[0]}) > MAX_S) ||
                    ($signed({hdr_cur[1][15], hdr_cur[1]}) > MAX_S);
  assign hdr_ok   = ($signed(hdr_cur[0]) > 16'sd0) && ($signed(hdr_cur[1]) > 16'sd0) &&
                    !oversize;

  // next state
  always_comb begin
    phase_d      = phase_q;
    bc_d         = bc_q;
    hdr_d        = hdr_cur;
    row_d        = row_q;
    col_d        = col_q;
    total_d      = total_q;
    seen_d       = seen_q;
    run_d        = run_q;
    line_rm_d    = line_rm_q;
    line_rot_d   = line_rot_q;
    addr_rm_d    = addr_rm_q;
    addr_rot_d   = addr_rot_q;
    area_d       = area_q;
    ar_en        = 1'b0;
    ar_col       = col_q;
    ar_seen      = seen_q;
    cnt_en       = 1'b0;
    cnt_next_row = 1'b0;
    row_c        = row_q;
    line_rm_c    = line_rm_q;
    line_rot_c   = line_rot_q;

    case (phase_q)
      rsd_pkg::PH_HEADER: begin
        if (bc_q >= 16'd7) begin
          area_d = ADDR_W'(hdr_cur[0][DIM_W-1:0]) * ADDR_W'(hdr_cur[1][DIM_W-1:0]);
          if (hdr_ok) begin
            phase_d    = rsd_pkg::PH_COUNT;
            row_d      = '0;
            line_rm_d  = '0;
            line_rot_d = hdr_cur[1][DIM_W-1:0] - DIM_W'(1);
          end else begin
            phase_d = rsd_pkg::PH_IDLE;
          end
        end
      end
      rsd_pkg::PH_COUNT: begin
        cnt_en = 1'b1;
      end
      rsd_pkg::PH_SKIP: begin
        if (skip_x >= COL_W'(w_u)) begin
          // row ends; the same byte is then the next row's count
          if (stop1) begin
            phase_d = rsd_pkg::PH_IDLE;
          end else begin
            row_d      = row_n;
            line_rm_d  = line_rm_n;
            line_rot_d = line_rot_n;
            if (row_n >= h_u) begin
              phase_d = rsd_pkg::PH_IDLE;
            end else begin
              cnt_en       = 1'b1;
              cnt_next_row = 1'b1;
            end
          end
        end else begin
          col_d      = skip_x;
          seen_d     = seen_inc;
          addr_rm_d  = addr_rm_q + ADDR_W'(byte_i);
          addr_rot_d = addr_rot_q + skip_rot;
          phase_d    = rsd_pkg::PH_RUNLEN;
        end
      end
      rsd_pkg::PH_RUNLEN: begin
        seen_d = seen_inc;
        if (byte_i == 8'd0) begin
          ar_en   = 1'b1;
          ar_seen = seen_inc;
        end else begin
          run_d   = byte_i;
          phase_d = rsd_pkg::PH_PIXEL;
        end
      end
      rsd_pkg::PH_PIXEL: begin
        col_d      = col_inc;
        addr_rm_d  = addr_rm_q + ADDR_W'(1);
        addr_rot_d = addr_rot_q + ADDR_W'(h_u);
        seen_d     = seen_inc;
        run_d      = run_q - 8'd1;
        if (run_q == 8'd1) begin
          ar_en   = 1'b1;
          ar_col  = col_inc;
          ar_seen = seen_inc;
        end
      end
      default: begin
      end
    endcase

    // end of a run
    if (ar_en) begin
      if (ar_col >= COL_W'(w_u) || ar_seen >= {1'b0, total_q}) begin
        if (stop2) begin
          phase_d = rsd_pkg::PH_IDLE;
        end else begin
          row_d      = row_n;
          line_rm_d  = line_rm_n;
          line_rot_d = line_rot_n;
          phase_d    = (row_n >= h_u) ? rsd_pkg::PH_IDLE : rsd_pkg::PH_COUNT;
        end
      end else begin
        phase_d = rsd_pkg::PH_SKIP;
      end
    end

    // row count byte
    if (cnt_en) begin
      if (cnt_next_row) begin
        row_c      = row_n;
        line_rm_c  = line_rm_n;
        line_rot_c = line_rot_n;
      end
      total_d = byte_i;
      seen_d  = 9'd1;
      if (byte_i == 8'd0) begin
        row_d      = row_c + DIM_W'(1);
        line_rm_d  = line_rm_c + ADDR_W'(w_u);
        line_rot_d = line_rot_c - DIM_W'(1);
        phase_d    = ((row_c + DIM_W'(1)) >= h_u) ? rsd_pkg::PH_IDLE : rsd_pkg::PH_COUNT;
      end else begin
        col_d      = '0;
        addr_rm_d  = line_rm_c;
        addr_rot_d = ADDR_W'(line_rot_c);
        phase_d    = rsd_pkg::PH_SKIP;
      end
    end

    if (done) begin
      phase_d    = rsd_pkg::PH_HEADER;
      bc_d       = '0;
      hdr_d      = '0;
      row_d      = '0;
      col_d      = '0;
      total_d    = '0;
      seen_d     = '0;
      run_d      = '0;
      line_rm_d  = '0;
      line_rot_d = '0;
      addr_rm_d  = '0;
      addr_rot_d = '0;
    end else begin
      bc_d = bc_q + 16'd1;
    end
  end

  // results of the byte at hand
  assign addr_sel = rotate_mode_i ? addr_rot_q : addr_rm_q;

  always_comb begin
    res_o                     = '0;
    res_o.pix_vld             = step_i && (phase_q == rsd_pkg::PH_PIXEL) && (addr_sel < area_q);
    res_o.pix.kind            = rsd_pkg::KIND_PIXEL;
    res_o.pix.pixel_address   = addr_sel[rsd_pkg::PIX_ADDR_W-1:0];
    res_o.pix.color_index     = byte_i;
    res_o.done_vld            = step_i && done;
    res_o.done.kind           = rsd_pkg::KIND_DONE;
    res_o.done.pic_width      = hdr_cur[0];
    res_o.done.pic_height     = hdr_cur[1];
    res_o.done.offset_x       = hdr_cur[2];
    res_o.done.offset_y       = hdr_cur[3];
    res_o.done.oversize       = oversize;
    res_o.done.last           = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rsd_pkg::PH_HEADER;
      bc_q       <= '0;
      hdr_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      total_q    <= '0;
      seen_q     <= '0;
      run_q      <= '0;
      line_rm_q  <= '0;
      line_rot_q <= '0;
      addr_rm_q  <= '0;
      addr_rot_q <= '0;
      area_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bc_q       <= bc_d;
      hdr_q      <= hdr_d;
      row_q      <= row_d;
      col_q      <= col_d;
      total_q    <= total_d;
      seen_q     <= seen_d;
      run_q      <= run_d;
      line_rm_q  <= line_rm_d;
      line_rot_q <= line_rot_d;
      addr_rm_q  <= addr_rm_d;
      addr_rot_q <= addr_rot_d;
      area_q     <= area_d;
    end
  end

  // header bytes are exactly the first eight of a record
  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rsd_pkg::PH_HEADER) == (bc_q <= 16'd7))
    else $error("header phase out of step with byte count");

  // a done result restarts the record
  a_done_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_vld |=> (phase_q == rsd_pkg::PH_HEADER) && (bc_q == 16'd0))
    else $error("record not restarted after done");

endmodule

// File: hw/rtl/rsd_outq.sv
// result queue of the run-length sprite decoder, takes up to two results a cycle
module rsd_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsd_pkg::step_res_t push_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output rsd_pkg::res_t      out_o,
  output logic               room_o
);

  localparam int DEPTH = rsd_pkg::OUTQ_DEPTH;
  localparam int PTR_W = rsd_pkg::OUTQ_PTR_W;
  localparam int CNT_W = rsd_pkg::OUTQ_CNT_W;

  rsd_pkg::res_t      mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   count_q;
  logic [1:0]         n_push;
  logic               pop, any_push, both_push;
  rsd_pkg::res_t      first;

  assign any_push  = push_i.pix_vld || push_i.done_vld;
  assign both_push = push_i.pix_vld && push_i.done_vld;
  assign n_push    = {1'b0, push_i.pix_vld} + {1'b0, push_i.done_vld};
  assign first     = push_i.pix_vld ? push_i.pix : push_i.done;

  assign out_valid_o = count_q != '0;
  assign out_o       = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = count_q <= CNT_W'(DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (any_push) begin
      mem_q[wr_q] <= first;
    end
    if (both_push) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PTR_W'(n_push);
      rd_q    <= rd_q + PTR_W'(pop);
      count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  // a push only comes while two entries are free
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_push |-> room_o)
    else $error("result pushed without room");

endmodule

// File: hw/rtl/rle_sprite_decoder_unit.sv
// top level of the run-length sprite decoder
//
// Bytes of a sprite record come in on the in channel, one item per byte,
// header first. Each opaque pixel leaves on the out channel as a pixel
// address and palette index; after the last byte of a record a done item
// carries the header words and the oversize flag. Both channels use valid
// and stall; an item moves on an edge with valid high and stall low.
// record_length and rotate_mode are written on the cfg port between items;
// the user must keep to this, as the block does not enforce it. A byte is
// registered on acceptance and is decoded once the result queue has room.
// Throughput: one byte per cycle while the queue has room; a byte that ends a
// record and also emits a pixel gives two items, which the out side takes one
// by one. The rate is set by the four-entry result queue, which takes a byte
// only while two entries are free.
// Reset clears the decoder to the start of a record and empties the queue.
// When the receiver stalls, the queue fills and the in channel stalls in turn.
module rle_sprite_decoder_unit #(
  parameter int MAX_DIM = rsd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [rsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_kind_o,
  output logic [rsd_pkg::PIX_ADDR_W-1:0] out_pixel_address_o,
  output logic [7:0]                     out_color_index_o,
  output logic signed [15:0]             out_pic_width_o,
  output logic signed [15:0]             out_pic_height_o,
  output logic signed [15:0]             out_offset_x_o,
  output logic signed [15:0]             out_offset_y_o,
  output logic                           out_oversize_o,
  output logic                           out_last_o
);

  logic [15:0]        record_length_q;
  logic               rotate_mode_q;
  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q;
  logic               accept, advance, room;
  rsd_pkg::step_res_t step_res;
  rsd_pkg::res_t      out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_length_q <= rsd_pkg::MIN_RECORD_LENGTH;
      rotate_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rsd_pkg::REG_RECORD_LENGTH: record_length_q <= cfg_data_i;
        rsd_pkg::REG_ROTATE_MODE:   rotate_mode_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // input register, drains into the decoder while the queue has room
  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_data_byte_i;
    end
  end

  rsd_core #(
    .MAX_DIM(MAX_DIM)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .byte_i         (in_byte_q),
    .record_length_i(record_length_q),
    .rotate_mode_i  (rotate_mode_q),
    .res_o          (step_res)
  );

  rsd_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step_res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_res),
    .room_o     (room)
  );

  assign out_kind_o          = out_res.kind;
  assign out_pixel_address_o = out_res.pixel_address;
  assign out_color_index_o   = out_res.color_index;
  assign out_pic_width_o     = $signed(out_res.pic_width);
  assign out_pic_height_o    = $signed(out_res.pic_height);
  assign out_offset_x_o      = $signed(out_res.offset_x);
  assign out_offset_y_o      = $signed(out_res.offset_y);
  assign out_oversize_o      = out_res.oversize;
  assign out_last_o          = out_res.last;

endmodule
